/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files of the junction detector
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BJPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// condition must never be true outside reset
`define BJPD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error(msg);

`endif

/* hw/rtl/bjpd_pkg.sv */
// types and constants of the black junction pixel detector
// no dependencies
`default_nettype none

package bjpd_pkg;

	localparam int CFG_W = 12;
	localparam int CFG_IDX_W = 1;
	localparam int CH_W = 8;
	localparam int OUT_W = 11;
	localparam int NB_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam int WIDTH_RESET = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int MIN_SIZE = 3;
	localparam int JUNCTION_MIN = 2;

	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [OUT_W-1:0] hit_row;
		logic [OUT_W-1:0] hit_col;
		logic [NB_W-1:0] black_neighbours;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/bjpd_fifo.sv */
// small first-in first-out queue of fixed-width entries
// uses assert_macros.svh; no package
`default_nettype none
`include "assert_macros.svh"

module bjpd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       rd,
	output logic      [WIDTH-1:0]           rdata,
	output logic                            full,
	output logic                            empty,
	output logic      [$clog2(DEPTH+1)-1:0] level
);
	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;

	assign full  = (level_q == LW'(DEPTH));
	assign empty = (level_q == '0);
	assign level = level_q;
	assign rdata = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				level_q <= level_q + 1'b1;
			end else if (rd && !wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

	`BJPD_ASSERT(a_level_bound, level_q <= LW'(DEPTH), "fifo level beyond depth")
	`BJPD_ASSERT(a_level_up, (wr && !rd) |=> (level_q == $past(level_q) + 1'b1), "fifo level did not rise")
	`BJPD_ASSERT(a_level_down, (rd && !wr) |=> (level_q == $past(level_q) - 1'b1), "fifo level did not fall")

endmodule

`default_nettype wire

/* hw/rtl/bjpd_front.sv */
// front end: size registers, raster position counters and black test
// uses bjpd_pkg
`default_nettype none

module bjpd_front #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bjpd_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [bjpd_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                               push,
	input  wire bjpd_pkg::pixel_t                   pixel,
	input  wire logic                               queue_full,
	output logic                                    item_wr,
	output logic      [$clog2(MAX_HEIGHT)-1:0]      item_row,
	output logic      [$clog2(MAX_WIDTH)-1:0]       item_col,
	output logic                                    item_black
);
	import bjpd_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RH  = $clog2(MAX_HEIGHT);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int XWW = (WW > CFG_W) ? WW : CFG_W;
	localparam int XHW = (HW > CFG_W) ? HW : CFG_W;
	localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

	function automatic logic [WW-1:0] clamp_w(logic [CFG_W-1:0] v);
		logic [XWW-1:0] x;
		logic [XWW-1:0] r;
		x = XWW'(v);
		if (x < XWW'(MIN_SIZE)) r = XWW'(MIN_SIZE);
		else if (x > XWW'(MAX_WIDTH)) r = XWW'(MAX_WIDTH);
		else r = x;
		return r[WW-1:0];
	endfunction

	function automatic logic [HW-1:0] clamp_h(logic [CFG_W-1:0] v);
		logic [XHW-1:0] x;
		logic [XHW-1:0] r;
		x = XHW'(v);
		if (x < XHW'(MIN_SIZE)) r = XHW'(MIN_SIZE);
		else if (x > XHW'(MAX_HEIGHT)) r = XHW'(MAX_HEIGHT);
		else r = x;
		return r[HW-1:0];
	endfunction

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [CW-1:0] col_q;
	logic [RH-1:0] row_q;

	logic          pre_wrap;
	logic [CW-1:0] col_cur;
	logic [HW-1:0] row_pre;
	logic [RH-1:0] row_cur;
	logic [WW-1:0] col_inc;
	logic [HW-1:0] row_inc;

	assign item_wr = push && !queue_full;

	// a size change while idle may leave the counters beyond the new size
	always_comb begin
		pre_wrap = (WW'(col_q) >= width_q);
		col_cur  = pre_wrap ? '0 : col_q;
		row_pre  = pre_wrap ? HW'(row_q) + 1'b1 : HW'(row_q);
		row_cur  = (row_pre >= height_q) ? '0 : row_pre[RH-1:0];
		col_inc  = WW'(col_cur) + 1'b1;
		row_inc  = HW'(row_cur) + 1'b1;
	end

	assign item_row   = row_cur;
	assign item_col   = col_cur;
	assign item_black = (pixel.blue == '0) && (pixel.green == '0) && (pixel.red == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RST);
			height_q <= HW'(H_RST);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:  width_q  <= clamp_w(cfg_data);
				REG_IMAGE_HEIGHT: height_q <= clamp_h(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (item_wr) begin
			if (col_inc >= width_q) begin
				col_q <= '0;
				row_q <= (row_inc >= height_q) ? '0 : row_inc[RH-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
				row_q <= row_cur;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bjpd_back.sv */
// back end: line buffer memory, 3x3 window and junction test
// uses bjpd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bjpd_back #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	input  wire logic [$clog2(MAX_HEIGHT)-1:0]      item_row,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]       item_col,
	input  wire logic                               item_black,
	output logic                                    item_pop,
	input  wire logic [bjpd_pkg::OUT_LVL_W-1:0]     out_level,
	output logic                                    res_push,
	output bjpd_pkg::result_t                       res
);
	import bjpd_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RH  = $clog2(MAX_HEIGHT);
	localparam int RXW = (RH > OUT_W) ? RH : OUT_W;
	localparam int CXW = (CW > OUT_W) ? CW : OUT_W;
	localparam int SW  = OUT_LVL_W + 1;

	// each entry: {row two above, row above}
	logic [1:0]    line_mem [MAX_WIDTH];
	logic [1:0]    line_rd_s1;

	logic          s1_v;
	logic [RH-1:0] row_s1;
	logic [CW-1:0] col_s1;
	logic          black_s1;
	logic [8:0]    win_q;

	logic          s2_v;
	result_t       res_s2;

	logic [SW-1:0] credit_used;
	logic [8:0]    win_n;
	logic [NB_W-1:0] neigh;
	logic          pos_ok;
	logic          hit;
	logic [RXW-1:0] row_ext;
	logic [CXW-1:0] col_ext;

	// results already queued or in flight reserve output queue slots
	assign credit_used = SW'(out_level) + SW'(s1_v) + SW'(s2_v);
	assign item_pop    = item_valid && (credit_used < SW'(OUT_DEPTH));

	always_ff @(posedge clk) begin
		if (item_pop) begin
			line_rd_s1 <= line_mem[item_col];
		end
		if (s1_v) begin
			line_mem[col_s1] <= {line_rd_s1[0], black_s1};
		end
	end

	always_comb begin
		win_n = {win_q[5:0], line_rd_s1[1], line_rd_s1[0], black_s1};
		neigh = '0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4) neigh = neigh + NB_W'(win_n[i]);
		end
		pos_ok  = (row_s1 >= RH'(2)) && (col_s1 >= CW'(2));
		hit     = s1_v & pos_ok & win_n[4] & (neigh > NB_W'(JUNCTION_MIN));
		row_ext = RXW'(row_s1) - RXW'(1);
		col_ext = CXW'(col_s1) - CXW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
		end else begin
			s1_v <= item_pop;
			s2_v <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			row_s1   <= item_row;
			col_s1   <= item_col;
			black_s1 <= item_black;
		end
		if (s1_v) begin
			win_q <= win_n;
		end
		if (hit) begin
			res_s2.hit_row          <= row_ext[OUT_W-1:0];
			res_s2.hit_col          <= col_ext[OUT_W-1:0];
			res_s2.black_neighbours <= neigh;
		end
	end

	assign res_push = s2_v;
	assign res      = res_s2;

	`BJPD_ASSERT(a_credit_bound, credit_used <= SW'(OUT_DEPTH), "output slots overbooked")
	`BJPD_ASSERT(a_pop_enters_s1, item_pop |=> s1_v, "popped item lost before line read")
	`BJPD_NEVER(a_push_no_room, s2_v && (out_level == OUT_LVL_W'(OUT_DEPTH)), "result pushed into full queue")

endmodule

`default_nettype wire

/* hw/rtl/black_junction_pixel_detector.sv */
// top level of the black junction pixel detector
// uses bjpd_pkg, bjpd_fifo, bjpd_front and bjpd_back
//
// pixels enter in raster order on a queue-like port: a request is taken at a
// rising edge with push high and full low. results leave the same way: while
// empty is low the oldest result sits on result, and pop high takes it.
// a pixel is black when red, green and blue are all zero. for every interior
// black pixel with three or more black neighbours one result gives its row,
// column and neighbour count; it is produced when the pixel diagonally
// below-right of it is taken, and goes through s1, s2 and the result queue.
// one pixel per clock is sustained; the front counts positions, the back
// reads and writes the line buffer memory once per pixel.
// a two-entry queue sits between front and back, a four-entry result queue
// at the output. when the receiver stalls, the back stops once the result
// queue has no free slot, the middle queue fills, and full rises.
// reset clears counters and queues and loads width 640 and height 480
// (clamped to the parameters); line buffer contents are undefined, which
// only touches rows that are never reported.
// sizes are written through cfg_we / cfg_idx / cfg_data while idle; values
// below 3 or above the maximum are clamped.
`default_nettype none

module black_junction_pixel_detector #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bjpd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [bjpd_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           push,
	output logic                                full,
	input  wire bjpd_pkg::pixel_t               pixel,
	output logic                                empty,
	input  wire logic                           pop,
	output bjpd_pkg::result_t                   result
);
	import bjpd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RH = $clog2(MAX_HEIGHT);
	localparam int MW = RH + CW + 1;

	// front side
	logic          item_wr;
	logic [RH-1:0] f_row;
	logic [CW-1:0] f_col;
	logic          f_black;

	// middle queue
	logic [MW-1:0] mid_wdata;
	logic [MW-1:0] mid_rdata;
	logic          mid_full;
	logic          mid_empty;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_level;
	logic          mid_pop;

	// result queue
	result_t              res_w;
	logic                 res_push;
	logic [OUT_LVL_W-1:0] out_level;
	logic [$bits(result_t)-1:0] out_rdata;
	logic                 out_pop;

	assign full = mid_full;

	bjpd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.push      (push),
		.pixel     (pixel),
		.queue_full(mid_full),
		.item_wr   (item_wr),
		.item_row  (f_row),
		.item_col  (f_col),
		.item_black(f_black)
	);

	// queue entry: {row, column, black flag}
	assign mid_wdata = {f_row, f_col, f_black};

	bjpd_fifo #(
		.WIDTH(MW),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (item_wr),
		.wdata (mid_wdata),
		.rd    (mid_pop),
		.rdata (mid_rdata),
		.full  (mid_full),
		.empty (mid_empty),
		.level (mid_level)
	);

	bjpd_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(!mid_empty && (mid_level != '0)),
		.item_row  (mid_rdata[MW-1 -: RH]),
		.item_col  (mid_rdata[CW:1]),
		.item_black(mid_rdata[0]),
		.item_pop  (mid_pop),
		.out_level (out_level),
		.res_push  (res_push),
		.res       (res_w)
	);

	// the result queue absorbs receiver stalls
	assign out_pop = pop && !empty;

	bjpd_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res_w),
		.rd    (out_pop),
		.rdata (out_rdata),
		.full  (),
		.empty (empty),
		.level (out_level)
	);

	assign result = result_t'(out_rdata);

endmodule

`default_nettype wire

/* verif/black_junction_pixel_detector_test.sv */
// self-checking testbench for black_junction_pixel_detector
// depends on bjpd_pkg and the detector rtl; predicts junction hits per accepted pixel
`timescale 1ns / 1ps

module black_junction_pixel_detector_test;

	import bjpd_pkg::*;

	localparam int LINE_MAX = 2048;
	localparam int ROWS_MAX = 2048;
	localparam int RANDOM_ITEMS = 345;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;

	// dut connections, inputs all known from time zero
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	pixel_t               pixel = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	result_t              result;

	// pixels waiting to be offered, and junction hits still to come out
	pixel_t  pending_pixels[$];
	result_t expected_hits[$];

	// pacing knobs, set by the sequence between phases
	int unsigned send_gap_max = 0;
	int unsigned recv_gap_max = 0;
	int unsigned holds_asked = 0;
	int unsigned mismatch_count = 0;

	// predictor state: size registers as written, line flags, window, position
	logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_RESET);
	logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_RESET);
	bit               upper_flags[LINE_MAX];
	bit               middle_flags[LINE_MAX];
	logic [8:0]       window_flags = '0;
	int unsigned      row_pos = 0;
	int unsigned      col_pos = 0;
	// writes per line column since reset, saturating at two
	int unsigned      line_writes[LINE_MAX];

	black_junction_pixel_detector #(
		.MAX_WIDTH(LINE_MAX),
		.MAX_HEIGHT(ROWS_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.pixel(pixel),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// sizes outside 3..max are pulled back into range
	function automatic int unsigned clamp_size(logic [CFG_W-1:0] value, int unsigned limit);
		if (value < MIN_SIZE)
			return MIN_SIZE;
		if (value > limit)
			return limit;
		return value;
	endfunction

	// advance the predicted frame by one pixel and queue a hit if the centre
	// one row up and one column left is a junction
	function void take_pixel(pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned neighbours;
		logic top;
		logic mid;
		logic dark;
		result_t hit;
		w = clamp_size(width_reg, LINE_MAX);
		h = clamp_size(height_reg, ROWS_MAX);
		// a size that shrank under the counters wraps them first
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		dark = (px.red == '0) && (px.green == '0) && (px.blue == '0);
		top = upper_flags[col_pos];
		mid = middle_flags[col_pos];
		upper_flags[col_pos] = mid;
		middle_flags[col_pos] = dark;
		if (line_writes[col_pos] < 2)
			line_writes[col_pos]++;
		// newest column in the low three bits: top, middle, bottom
		window_flags = {window_flags[5:0], top, mid, dark};
		if (row_pos >= 2 && col_pos >= 2) begin
			neighbours = $countones(window_flags) - window_flags[4];
			if (window_flags[4] && neighbours > JUNCTION_MIN) begin
				hit.hit_row = OUT_W'(row_pos - 1);
				hit.hit_col = OUT_W'(col_pos - 1);
				hit.black_neighbours = NB_W'(neighbours);
				expected_hits = {expected_hits, hit};
			end
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	// how many of the next n pixels may be sent with the given sizes: a pixel
	// in row two or below must land on a line column already written twice
	function automatic int unsigned safe_run(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv,
			int unsigned n);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned k;
		int unsigned seen[LINE_MAX];
		w = clamp_size(wv, LINE_MAX);
		h = clamp_size(hv, ROWS_MAX);
		r = row_pos;
		c = col_pos;
		seen = line_writes;
		for (k = 0; k < n; k++) begin
			if (c >= w) begin
				c = 0;
				r++;
			end
			if (r >= h)
				r = 0;
			if (r >= 2 && seen[c] < 2)
				return k;
			if (seen[c] < 2)
				seen[c]++;
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h)
					r = 0;
			end
		end
		return n;
	endfunction

	// mostly black when asked, otherwise one channel set or all random
	function automatic pixel_t random_pixel(int unsigned black_pct);
		pixel_t px;
		px = '0;
		if ($urandom_range(99) >= black_pct) begin
			case ($urandom_range(3))
				0: px.red = 8'($urandom_range(255, 1));
				1: px.green = 8'($urandom_range(255, 1));
				2: px.blue = 8'($urandom_range(255, 1));
				default: px = pixel_t'(24'($urandom));
			endcase
		end
		return px;
	endfunction

	// one 3x3 frame, mask bit k set means pixel k in raster order is black;
	// the others rotate through single-channel and all-ones colors
	task automatic queue_small_frame(input logic [8:0] mask);
		pixel_t px;
		int k;
		for (k = 0; k < 9; k++) begin
			px = '0;
			if (!mask[k]) begin
				case (k % 4)
					0: px.red = 8'd1;
					1: px.green = 8'h80;
					2: px.blue = 8'hFF;
					default: px = '1;
				endcase
			end
			pending_pixels = {pending_pixels, px};
		end
	endtask

	// block is idle once every pixel is taken and every hit has come out;
	// pixels that make no hit may still be in flight, so wait for them to drain
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || push || expected_hits.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = value;
		else
			height_reg = value;
	endtask

	// new frame size plus pacing for the next phase; ends on a falling edge
	// so the caller can fill the pixel queue without racing the driver
	task automatic start_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input int unsigned send_max, input int unsigned recv_max);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		@(negedge clk);
		send_gap_max = send_max;
		recv_gap_max = recv_max;
	endtask

	// driver: offers the head of the pixel queue, keeps a request up while
	// full is high, and idles a random number of cycles after each request
	int unsigned send_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_wait = 0;
		end else begin
			if (push && !full) begin
				take_pixel(pixel);
				void'(pending_pixels.pop_front());
				send_wait = $urandom_range(send_gap_max, 0);
			end
			// a stalled request stays on the port untouched
			if (!push || !full) begin
				if (send_wait > 0) begin
					send_wait--;
					push <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					push <= 1'b1;
					pixel <= pending_pixels[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each taken hit against the oldest prediction, then
	// pauses pop at random; a long hold-off on request backs the block up
	int unsigned pop_wait = 0;
	int unsigned hold_left = 0;
	int unsigned holds_done = 0;
	result_t     oldest_hit;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_wait = 0;
			hold_left = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_hits.size() == 0) begin
					$error("unexpected hit: row %0d col %0d neighbours %0d",
						result.hit_row, result.hit_col, result.black_neighbours);
					mismatch_count++;
				end else begin
					oldest_hit = expected_hits.pop_front();
					if (result.hit_row !== oldest_hit.hit_row) begin
						$error("hit_row: expected %0d, actual %0d",
							oldest_hit.hit_row, result.hit_row);
						mismatch_count++;
					end
					if (result.hit_col !== oldest_hit.hit_col) begin
						$error("hit_col: expected %0d, actual %0d",
							oldest_hit.hit_col, result.hit_col);
						mismatch_count++;
					end
					if (result.black_neighbours !== oldest_hit.black_neighbours) begin
						$error("black_neighbours: expected %0d, actual %0d",
							oldest_hit.black_neighbours, result.black_neighbours);
						mismatch_count++;
					end
				end
				pop_wait = $urandom_range(recv_gap_max, 0);
			end
			if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (pop_wait > 0) begin
				pop_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// run-away guard
	initial begin : watchdog
		int unsigned cycle_cnt;
		for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin : sequence_main
		int unsigned fed;
		int unsigned n;
		int unsigned k;
		int unsigned black_pct;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: sizes below the minimum clamp to 3x3; all-black frame
		// gives an eight-neighbour hit, a diagonal line has too few
		// neighbours, a T shape gives exactly three
		start_phase(12'd0, 12'd1, 0, 8);
		queue_small_frame(9'b111111111);
		queue_small_frame(9'b100010001);
		queue_small_frame(9'b000111010);

		// back-pressure: receiver holds off while dark pixels pour in,
		// result queue fills and full must rise
		start_phase(12'd6, 12'd2048, 0, 0);
		holds_asked++;
		for (k = 0; k < 80; k++)
			pending_pixels = {pending_pixels, random_pixel(95)};

		// random phases; size changes land mid-frame since the phase
		// lengths don't line up with the frame
		fed = 0;
		while (fed < RANDOM_ITEMS) begin
			n = $urandom_range(60, 15);
			case ($urandom_range(9))
				0: w = CFG_W'($urandom_range(2));
				1: begin
					w = ($urandom_range(1)) ? CFG_W'(LINE_MAX) : CFG_W'($urandom_range(4095, 2049));
					n = $urandom_range(30, 10);
				end
				default: w = CFG_W'($urandom_range(24, 3));
			endcase
			case ($urandom_range(9))
				0: h = CFG_W'($urandom_range(2));
				1: h = ($urandom_range(1)) ? CFG_W'(ROWS_MAX) : CFG_W'($urandom_range(4095, 2049));
				default: h = CFG_W'($urandom_range(12, 3));
			endcase
			black_pct = $urandom_range(95, 40);
			start_phase(w, h, $urandom_range(1) ? 8 : 0, $urandom_range(1) ? 8 : 0);
			// a wider row may only run as far as the line columns already filled
			n = safe_run(w, h, n);
			for (k = 0; k < n; k++)
				pending_pixels = {pending_pixels, random_pixel(black_pct)};
			fed += n;
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bjpd_pkg.sv
hw/rtl/bjpd_fifo.sv
hw/rtl/bjpd_front.sv
hw/rtl/bjpd_back.sv
hw/rtl/black_junction_pixel_detector.sv
verif/black_junction_pixel_detector_test.sv
